// ----- rtl/core/mpwa_pkg.sv -----
// Shared types and constants of the max pooling window argmax block.
package mpwa_pkg;

	localparam int ROW_W    = 6;
	localparam int COL_W    = 6;
	localparam int PLANE_W  = 16;
	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = 28;
	localparam int WIDTH_W  = 7;
	localparam int HEIGHT_W = 7;
	localparam int WIN_W    = 4;
	localparam int STRIDE_W = 4;
	localparam int PAD_W    = 4;
	localparam int POS_W    = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 48;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAD         = 3'd4;

	localparam logic signed [SAMPLE_W-1:0] MOST_NEG = 16'sh8000;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [INDEX_W-1:0] index_t;

endpackage

// ----- rtl/core/max_pool_window_argmax.sv -----
// Top level: plane store and iterative window maximum search with argmax.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser command; tdata row, col, plane_number, sample_value
// m_*      out  m_tvalid/m_tready  tuser found; tdata max_value, max_index
// cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// A load beat with row < MAX_HEIGHT and col < MAX_WIDTH is written to the store in
// the cycle it is accepted. A compute beat reads the store once per window position
// inside the plane through a single read port and one compare unit, after setup of
// the window origin and flat index base, then drains the read and loads the result.
// arst_n resets control and sets the configuration registers to their defaults; the store contents stay undefined.
// The result waits in an output register; a stalled m_tready holds only the final step.
module max_pool_window_argmax #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_WINDOW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [mpwa_pkg::S_TDATA_W-1:0] s_tdata, // row, col, plane_number, sample_value, pad
	input  logic s_tuser,                            // command
	output logic m_tvalid,
	input  logic m_tready,
	output logic [mpwa_pkg::M_TDATA_W-1:0] m_tdata, // max_value, max_index, pad
	output logic m_tuser,                            // found
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mpwa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpwa_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);
	localparam logic [10:0] W_LIM = 11'(MAX_WIDTH);
	localparam logic [10:0] H_LIM = 11'(MAX_HEIGHT);
	localparam logic [4:0] K_LIM = 5'(MAX_WINDOW);
	localparam logic [mpwa_pkg::WIDTH_W-1:0] W_RST =
		mpwa_pkg::WIDTH_W'((MAX_WIDTH < 64) ? MAX_WIDTH : 64);
	localparam logic [mpwa_pkg::HEIGHT_W-1:0] H_RST =
		mpwa_pkg::HEIGHT_W'((MAX_HEIGHT < 64) ? MAX_HEIGHT : 64);
	localparam logic [mpwa_pkg::WIN_W-1:0] K_RST =
		mpwa_pkg::WIN_W'((MAX_WINDOW < 2) ? MAX_WINDOW : 2);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_BASE   = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;

	logic [mpwa_pkg::WIDTH_W-1:0]  in_width_q;
	logic [mpwa_pkg::HEIGHT_W-1:0] in_height_q;
	logic [mpwa_pkg::WIN_W-1:0]    window_q;
	logic [mpwa_pkg::STRIDE_W-1:0] stride_q;
	logic [mpwa_pkg::PAD_W-1:0]    pad_q;

	logic [mpwa_pkg::ROW_W-1:0]    in_row;
	logic [mpwa_pkg::COL_W-1:0]    in_col;
	logic [mpwa_pkg::PLANE_W-1:0]  in_plane;
	logic [mpwa_pkg::SAMPLE_W-1:0] in_sample;

	logic [mpwa_pkg::ROW_W-1:0]   row_q;
	logic [mpwa_pkg::COL_W-1:0]   col_q;
	logic [mpwa_pkg::PLANE_W-1:0] plane_q;

	mpwa_pkg::pos_t r0_q;
	mpwa_pkg::pos_t c0_q;
	logic [22:0] hp_q;
	mpwa_pkg::index_t rbase_q;
	logic [mpwa_pkg::WIN_W-1:0] n_q;
	logic [mpwa_pkg::WIN_W-1:0] m_q;

	logic [mpwa_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [mpwa_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic vld_s1;
	logic [mpwa_pkg::WIDTH_W-1:0] c_s1;
	mpwa_pkg::index_t rbase_s1;

	logic signed [mpwa_pkg::SAMPLE_W-1:0] best_q;
	mpwa_pkg::index_t best_idx_q;
	logic found_q;

	logic out_valid_q;
	logic signed [mpwa_pkg::SAMPLE_W-1:0] out_value_q;
	mpwa_pkg::index_t out_index_q;
	logic out_found_q;

	logic in_fire;
	logic load_we;
	logic [AW-1:0] load_addr;
	logic [9:0] row_mul;
	logic [9:0] col_mul;
	mpwa_pkg::pos_t half_pad;
	mpwa_pkg::index_t base_sum;
	logic [34:0] base_prod;
	mpwa_pkg::pos_t r_cur;
	mpwa_pkg::pos_t c_cur;
	logic pos_valid;
	logic [AW-1:0] rd_addr;
	logic row_end;
	logic win_end;
	logic fin_load;

	assign in_row    = s_tdata[5:0];
	assign in_col    = s_tdata[11:6];
	assign in_plane  = s_tdata[27:12];
	assign in_sample = s_tdata[43:28];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign load_we = in_fire && (s_tuser == mpwa_pkg::CMD_LOAD)
		&& ({5'b0, in_row} < H_LIM) && ({5'b0, in_col} < W_LIM);
	assign load_addr = AW'(in_row) * ROW_STEP + AW'(in_col);

	assign row_mul  = 10'(row_q) * 10'(stride_q);
	assign col_mul  = 10'(col_q) * 10'(stride_q);
	assign half_pad = mpwa_pkg::POS_W'(pad_q >> 1);

	assign base_sum  = {5'b0, hp_q} + {{(mpwa_pkg::INDEX_W-mpwa_pkg::POS_W){r0_q[11]}}, r0_q};
	assign base_prod = 35'(base_sum) * 35'(in_width_q);

	assign r_cur = r0_q + mpwa_pkg::POS_W'(n_q);
	assign c_cur = c0_q + mpwa_pkg::POS_W'(m_q);
	assign pos_valid = !r_cur[11] && !c_cur[11]
		&& (r_cur < mpwa_pkg::POS_W'(in_height_q))
		&& (c_cur < mpwa_pkg::POS_W'(in_width_q));
	assign rd_addr = AW'(r_cur[6:0]) * ROW_STEP + AW'(c_cur[6:0]);

	assign row_end  = (m_q == window_q - 4'd1);
	assign win_end  = row_end && (n_q == window_q - 4'd1);
	assign fin_load = (state_q == ST_FINISH) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= W_RST;
			in_height_q <= H_RST;
			window_q    <= K_RST;
			stride_q    <= 4'd2;
			pad_q       <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mpwa_pkg::REG_IN_WIDTH: begin
					in_width_q <= ({4'b0, cfg_data} > W_LIM) ? W_LIM[6:0] : cfg_data;
				end
				mpwa_pkg::REG_IN_HEIGHT: begin
					in_height_q <= ({4'b0, cfg_data} > H_LIM) ? H_LIM[6:0] : cfg_data;
				end
				mpwa_pkg::REG_WINDOW_SIZE: begin
					window_q <= ({1'b0, cfg_data[3:0]} > K_LIM) ? K_LIM[3:0] : cfg_data[3:0];
				end
				mpwa_pkg::REG_STRIDE: stride_q <= cfg_data[3:0];
				mpwa_pkg::REG_PAD:    pad_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[load_addr] <= in_sample;
		end
		if (state_q == ST_SCAN && pos_valid) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			n_q     <= '0;
			m_q     <= '0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN) && pos_valid;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && s_tuser == mpwa_pkg::CMD_COMPUTE) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					found_q <= 1'b0;
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					n_q <= '0;
					m_q <= '0;
					state_q <= (window_q == 4'd0) ? ST_FINISH : ST_SCAN;
				end
				ST_SCAN: begin
					if (row_end) begin
						m_q <= '0;
						n_q <= n_q + 4'd1;
					end else begin
						m_q <= m_q + 4'd1;
					end
					if (win_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (vld_s1 && $signed(rd_data_s1) > best_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_q   <= in_row;
			col_q   <= in_col;
			plane_q <= in_plane;
		end
		if (state_q == ST_PREP) begin
			r0_q       <= mpwa_pkg::POS_W'(row_mul) - half_pad;
			c0_q       <= mpwa_pkg::POS_W'(col_mul) - half_pad;
			hp_q       <= 23'(in_height_q) * 23'(plane_q);
			best_q     <= mpwa_pkg::MOST_NEG;
			best_idx_q <= '0;
		end
		if (state_q == ST_BASE) begin
			rbase_q <= base_prod[mpwa_pkg::INDEX_W-1:0];
		end else if (state_q == ST_SCAN && row_end) begin
			rbase_q <= rbase_q + mpwa_pkg::INDEX_W'(in_width_q);
		end
		if (state_q == ST_SCAN) begin
			c_s1     <= c_cur[6:0];
			rbase_s1 <= rbase_q;
		end
		if (vld_s1 && $signed(rd_data_s1) > best_q) begin
			best_q     <= $signed(rd_data_s1);
			best_idx_q <= rbase_s1 + mpwa_pkg::INDEX_W'(c_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_value_q <= best_q;
			out_index_q <= best_idx_q;
			out_found_q <= found_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_index_q, out_value_q};
	assign m_tuser  = out_found_q;

endmodule
